[rtl/fkg_pkg.sv]
// Package with shared constants and types for the fractional knapsack block.
package fkg_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W = 20;
  localparam int WGT_W = 20;
  localparam int CAP_W = 26;
  localparam int TOTAL_W = 42;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Item handed from the front end to the back end.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [WGT_W-1:0] weight;
    logic             last;
  } item_t;

endpackage

[rtl/fkg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fkg_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fkg_front.sv]
// Front end: accepts item transfers and pushes them into a short queue.
module fkg_front #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fkg_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_ready,
  output fkg_pkg::item_t q_item
);

  localparam int AW = $clog2(DEPTH);

  fkg_pkg::item_t buf_q [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic push;
  logic pop;

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = buf_q[rptr];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      buf_q[wptr] <= in_item;
    end
  end

endmodule

[rtl/fkg_back.sv]
// Back end: stores a batch, sorts it, runs the greedy pass and divides.
module fkg_back #(
  parameter int MAX_ITEMS = fkg_pkg::MAX_ITEMS_DEF,
  parameter int FRAC_BITS = fkg_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fkg_pkg::CAP_W-1:0]   capacity,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  fkg_pkg::item_t              q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fkg_pkg::TOTAL_W-1:0] out_total,
  output logic                        out_dropped
);

  localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int VW  = fkg_pkg::VAL_W;
  localparam int WW  = fkg_pkg::WGT_W;
  localparam int PW  = VW + WW;
  localparam int NW  = fkg_pkg::CAP_W + VW;   // fraction numerator v*rem
  localparam int QW  = NW + FRAC_BITS;        // quotient with fraction bits
  localparam int SW  = VW + CW + FRAC_BITS + 1;
  localparam int TW  = fkg_pkg::TOTAL_W;

  typedef enum logic [3:0] {
    S_LOAD, S_SORT_RD, S_SORT_ORD, S_SORT_WAIT, S_SORT_CMP, S_SORT_WR,
    S_GR_RD, S_GR_WAIT, S_GR_STEP, S_DIV, S_DONE, S_OUT
  } state_t;

  state_t state;

  logic [CW-1:0] count;
  logic          overflow;
  logic [CW-1:0] n_sorted;
  logic [CW-1:0] pos;
  logic [CW-1:0] idx;
  logic [AW-1:0] cur;
  logic [AW-1:0] ord_j;
  logic [VW-1:0] cur_v;
  logic [WW-1:0] cur_w;
  logic [fkg_pkg::CAP_W-1:0] remaining;
  logic [SW-1:0] whole;
  logic [QW-1:0] div_q;
  logic [NW+WW:0] div_r;
  logic [WW-1:0]  div_d;
  logic [$clog2(QW+1)-1:0] div_cnt;
  logic [PW-1:0]  prod_l;
  logic [PW-1:0]  prod_r;
  logic           cmp_phase;

  // Store ports.
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [VW-1:0] rd_v;
  logic [WW-1:0] rd_w;

  // Order store ports.
  logic          ord_we;
  logic [AW-1:0] ord_waddr;
  logic [AW-1:0] ord_wdata;
  logic [AW-1:0] ord_raddr;
  logic [AW-1:0] ord_rdata;

  assign we    = (state == S_LOAD) && q_valid && (count != CW'(MAX_ITEMS));
  assign waddr = count[AW-1:0];

  fkg_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_vram (
    .clk, .we, .waddr, .wdata(q_item.value), .raddr, .rdata(rd_v)
  );
  fkg_ram #(.WIDTH(WW), .DEPTH(MAX_ITEMS)) u_wram (
    .clk, .we, .waddr, .wdata(q_item.weight), .raddr, .rdata(rd_w)
  );

  // Sorted order of item indexes; one read and one write per cycle.
  assign ord_we    = (state == S_SORT_WR) ||
                     ((state == S_SORT_CMP) && (prod_l > prod_r));
  assign ord_waddr = pos[AW-1:0];
  assign ord_wdata = (state == S_SORT_WR) ? cur : ord_j;
  assign ord_raddr = (state == S_GR_RD) ? idx[AW-1:0] : pos[AW-1:0] - 1'b1;

  fkg_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_oram (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  // Read address depends on the phase of the sequencer.
  always_comb begin
    raddr = idx[AW-1:0];
    if (state == S_SORT_ORD || state == S_GR_WAIT) begin
      raddr = ord_rdata;
    end
  end

  assign q_ready     = (state == S_LOAD);
  assign out_valid   = (state == S_OUT);
  assign out_dropped = overflow;

  // Sequencer: load, insertion sort, greedy pass, restoring divide, output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (q_valid) begin
            if (count != CW'(MAX_ITEMS)) begin
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            if (q_item.last) begin
              state     <= S_SORT_RD;
              idx       <= '0;
              n_sorted  <= '0;
              cmp_phase <= 1'b0;
            end
          end
        end
        S_SORT_RD: begin
          if (!cmp_phase && idx == count) begin
            state     <= S_GR_RD;
            idx       <= '0;
            remaining <= capacity;
            whole     <= '0;
            div_q     <= '0;
          end else if (cmp_phase) begin
            state <= S_SORT_ORD;
          end else begin
            state <= S_SORT_WAIT;
          end
        end
        S_SORT_ORD: begin
          ord_j <= ord_rdata;
          state <= S_SORT_WAIT;
        end
        S_SORT_WAIT: begin
          if (!cmp_phase) begin
            cur   <= idx[AW-1:0];
            cur_v <= rd_v;
            cur_w <= rd_w;
            if (rd_w == '0) begin
              idx   <= idx + 1'b1;
              state <= S_SORT_RD;
            end else begin
              pos       <= n_sorted;
              cmp_phase <= 1'b1;
              state     <= (n_sorted == '0) ? S_SORT_WR : S_SORT_RD;
            end
          end else begin
            prod_l <= cur_v * rd_w;
            prod_r <= rd_v * cur_w;
            state  <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (prod_l > prod_r) begin
            pos <= pos - 1'b1;
            state <= (pos == CW'(1)) ? S_SORT_WR : S_SORT_RD;
          end else begin
            state <= S_SORT_WR;
          end
        end
        S_SORT_WR: begin
          n_sorted  <= n_sorted + 1'b1;
          idx       <= idx + 1'b1;
          cmp_phase <= 1'b0;
          state     <= S_SORT_RD;
        end
        S_GR_RD: begin
          if (idx == n_sorted || remaining == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_GR_WAIT;
          end
        end
        S_GR_WAIT: begin
          state <= S_GR_STEP;
        end
        S_GR_STEP: begin
          if ({{(fkg_pkg::CAP_W-WW){1'b0}}, rd_w} <= remaining) begin
            whole     <= whole + SW'(rd_v);
            remaining <= remaining - fkg_pkg::CAP_W'(rd_w);
            idx       <= idx + 1'b1;
            state     <= S_GR_RD;
          end else begin
            // Numerator v*rem shifted left by FRAC_BITS, divided bit by bit.
            div_q   <= QW'(rd_v * remaining) << FRAC_BITS;
            div_r   <= '0;
            div_d   <= rd_w;
            div_cnt <= ($clog2(QW+1))'(QW);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_DONE;
          end else begin
            div_cnt <= div_cnt - 1'b1;
            if ({div_r[NW+WW-1:0], div_q[QW-1]} >= (NW+WW+1)'(div_d)) begin
              div_r <= {div_r[NW+WW-1:0], div_q[QW-1]} - (NW+WW+1)'(div_d);
              div_q <= {div_q[QW-2:0], 1'b1};
            end else begin
              div_r <= {div_r[NW+WW-1:0], div_q[QW-1]};
              div_q <= {div_q[QW-2:0], 1'b0};
            end
          end
        end
        S_DONE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state    <= S_LOAD;
            count    <= '0;
            overflow <= 1'b0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Total: whole part shifted plus the fractional quotient; saturate.
  logic [QW+SW:0] total_full;
  always_comb begin
    total_full = ((QW+SW+1)'(whole) << FRAC_BITS) + (QW+SW+1)'(div_q);
    if (total_full > (QW+SW+1)'(fkg_pkg::TOTAL_MAX)) begin
      out_total = fkg_pkg::TOTAL_MAX;
    end else begin
      out_total = total_full[TW-1:0];
    end
  end

endmodule

[rtl/fractional_knapsack_greedy.sv]
// Top level of the fractional knapsack greedy block.
//
// Items arrive on the s_axis channel, one transfer per cycle while the queue
// has room: tdata carries item_value and item_weight, tlast ends the batch.
// Configuration: cfg_we writes capacity from cfg_wdata; the user must do so
// only while the block idles, as the block itself does not enforce this.
// After the last item the back end sorts the stored items with an insertion
// sort (up to N*(N-1)/2 compares), runs the greedy pass and a bit-serial
// divide at 16 fraction bits, then offers one result on m_axis.
// Throughput while loading is one item per cycle; the batch latency is set
// by the single store read port used by the sort. The result is held until
// m_axis_tready; items keep filling the front queue meanwhile. rst clears
// the queue, the batch count and the overflow flag; the store contents need
// no clearing.
// m_axis tdata: total_value in bits 41:0; tuser: items_dropped.
module fractional_knapsack_greedy #(
  parameter int MAX_ITEMS = fkg_pkg::MAX_ITEMS_DEF,
  parameter int FRAC_BITS = fkg_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [25:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // item_value [19:0], item_weight [39:20]
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // total_value [41:0], zero fill above
  output logic        m_axis_tuser    // items_dropped
);

  logic [fkg_pkg::CAP_W-1:0] capacity;
  fkg_pkg::item_t in_item;
  fkg_pkg::item_t q_item;
  logic q_valid;
  logic q_ready;
  logic [fkg_pkg::TOTAL_W-1:0] total;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign in_item.value  = s_axis_tdata[19:0];
  assign in_item.weight = s_axis_tdata[39:20];
  assign in_item.last   = s_axis_tlast;

  fkg_front #(.DEPTH(4)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  fkg_back #(.MAX_ITEMS(MAX_ITEMS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .capacity,
    .q_valid, .q_ready, .q_item,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_total(total), .out_dropped(m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, total};

endmodule

[dv/fkg_checker.sv]
// Checker for the fractional knapsack block: tracks batches, predicts the loot and compares.
module fkg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [25:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = fkg_pkg::MAX_ITEMS_DEF;
  localparam int FRAC = fkg_pkg::FRAC_BITS_DEF;
  localparam int TW = fkg_pkg::TOTAL_W;

  typedef struct packed {
    logic [TW-1:0] total;
    logic          dropped;
  } loot_t;

  logic [fkg_pkg::CAP_W-1:0] cap_reg;
  logic [fkg_pkg::VAL_W-1:0] batch_value [SLOTS];
  logic [fkg_pkg::WGT_W-1:0] batch_weight [SLOTS];
  int               batch_len;
  logic             batch_overflow;
  loot_t            loot_queue [$];

  // Greedy loot of the current batch, best value per weight first.
  function automatic logic [TW-1:0] greedy_loot();
    int          rank [SLOTS];
    int          n;
    int          pos;
    bit [63:0]   remaining;
    bit [63:0]   whole;
    bit [63:0]   part;
    bit [63:0]   prod;
    bit [63:0]   v;
    bit [63:0]   w;
    bit [63:0]   sum;
    n = 0;
    remaining = cap_reg;
    whole = 0;
    part = 0;
    // Stable insertion by cross products; zero weights stay out.
    for (int i = 0; i < batch_len; i++) begin
      if (batch_weight[i] != 0) begin
        pos = n;
        while (pos > 0 &&
               64'(batch_value[i]) * batch_weight[rank[pos-1]] >
               64'(batch_value[rank[pos-1]]) * batch_weight[i]) begin
          rank[pos] = rank[pos-1];
          pos--;
        end
        rank[pos] = i;
        n++;
      end
    end
    for (int i = 0; i < n && remaining > 0; i++) begin
      v = batch_value[rank[i]];
      w = batch_weight[rank[i]];
      if (w <= remaining) begin
        whole += v;
        remaining -= w;
      end else begin
        prod = v * remaining;
        whole += prod / w;
        part = ((prod % w) << FRAC) / w;
        remaining = 0;
      end
    end
    sum = (whole << FRAC) + part;
    if (sum > 64'(fkg_pkg::TOTAL_MAX))
      sum = 64'(fkg_pkg::TOTAL_MAX);
    return sum[TW-1:0];
  endfunction

  // Follow register writes, item transfers and result transfers.
  always @(posedge clk) begin
    loot_t exp_loot;
    if (rst) begin
      cap_reg <= '0;
      batch_len = 0;
      batch_overflow = 1'b0;
      loot_queue.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we)
        cap_reg <= cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        if (loot_queue.size() == 0) begin
          $display("%0t: unexpected result transfer, total %h dropped %b", $time,
                   m_axis_tdata[TW-1:0], m_axis_tuser);
          errors <= errors + 1;
        end else begin
          exp_loot = loot_queue.pop_front();
          if (m_axis_tdata[TW-1:0] !== exp_loot.total ||
              m_axis_tuser !== exp_loot.dropped) begin
            $display("%0t: mismatch, expected total %h dropped %b, got total %h dropped %b",
                     $time, exp_loot.total, exp_loot.dropped,
                     m_axis_tdata[TW-1:0], m_axis_tuser);
            errors <= errors + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (batch_len < SLOTS) begin
          batch_value[batch_len] = s_axis_tdata[19:0];
          batch_weight[batch_len] = s_axis_tdata[39:20];
          batch_len++;
        end else begin
          batch_overflow = 1'b1;
        end
        if (s_axis_tlast) begin
          exp_loot.total = greedy_loot();
          exp_loot.dropped = batch_overflow;
          loot_queue.push_back(exp_loot);
          batch_len = 0;
          batch_overflow = 1'b0;
        end
      end
      pending <= loot_queue.size();
    end
  end

endmodule

[dv/testbench.sv]
// Top of the fractional knapsack testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [25:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          burst_left;
  int          items_sent;
  int          stall_mode;

  fractional_knapsack_greedy dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  fkg_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver readiness under a randomly chosen stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (cycles % 64 == 0)
        stall_mode <= int'($urandom_range(0, 3));
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 9) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  // One item transfer; the sender runs in bursts with random gaps between.
  task automatic send_item(input logic [19:0] value, input logic [19:0] weight,
                           input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = int'($urandom_range(1, 20));
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {weight, value};
    s_axis_tlast <= last;
    // tready settles well before the edge, so look at it mid cycle.
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Capacity change, made only while no result is outstanding.
  task automatic set_capacity(input logic [25:0] cap);
    s_axis_tvalid <= 1'b0;
    // Let the count of outstanding results take in the last item transfer.
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A batch of random items; wide selects full range weights.
  task automatic send_batch(input int count, input bit wide);
    logic [19:0] w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        w = '0;
      else if (wide)
        w = 20'($urandom_range(1, 20'hFFFFF));
      else
        w = 20'($urandom_range(1, 1000));
      send_item(20'($urandom_range(0, 20'hFFFFF)), w, i == count - 1);
    end
  endtask

  initial begin
    int count;
    logic [25:0] cap;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero capacity takes nothing.
    send_item(20'd1000, 20'd10, 1'b1);
    // Largest capacity with extreme fields and zero weights.
    set_capacity(26'h3FFFFFF);
    send_item(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_item(20'hFFFFF, 20'd1, 1'b0);
    send_item(20'd0, 20'd5, 1'b0);
    send_item(20'd7, 20'd0, 1'b1);
    // Tied ratios, the second of the tied items taken only in part.
    set_capacity(26'd100);
    send_item(20'd300, 20'd50, 1'b0);
    send_item(20'd600, 20'd100, 1'b0);
    send_item(20'd5, 20'd3, 1'b0);
    send_item(20'd1, 20'hFFFFF, 1'b1);
    // Batches with nothing that weighs anything.
    send_item(20'd0, 20'd0, 1'b1);
    send_item(20'hFFFFF, 20'd0, 1'b1);
    // Overfull batch, the final item among the dropped ones.
    set_capacity(26'd5000);
    send_batch(66, 1'b0);

    // Random phases, each with its own capacity.
    while (items_sent < 900) begin
      case ($urandom_range(0, 5))
        0: cap = '0;
        1: cap = 26'h3FFFFFF;
        2: cap = 26'($urandom_range(0, 5000));
        3: cap = 26'($urandom_range(0, 3000000));
        default: cap = 26'($urandom_range(0, 26'h3FFFFFF));
      endcase
      set_capacity(cap);
      repeat ($urandom_range(1, 6)) begin
        count = ($urandom_range(0, 14) == 0) ? int'($urandom_range(60, 68))
                                              : int'($urandom_range(1, 10));
        send_batch(count, 1'($urandom_range(0, 1)));
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/fkg_pkg.sv
rtl/fkg_ram.sv
rtl/fkg_front.sv
rtl/fkg_back.sv
rtl/fractional_knapsack_greedy.sv
dv/fkg_checker.sv
dv/testbench.sv
